>>> sv/odo_pkg.sv
// Shared constants, register indexes and the arctangent table for the odometry core.
package odo_pkg;

  // Default number of CORDIC iterations and the size of the arctangent table.
  localparam int unsigned CordicItersDefault = 16;
  localparam int unsigned AtanEntries        = 24;
  localparam int unsigned AtanIdxW           = 5;

  // Field and datapath widths.
  localparam int unsigned DeltaW   = 16;
  localparam int unsigned PosW     = 32;
  localparam int unsigned AngleW   = 32;
  localparam int unsigned ScaleW   = 24;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned MulW     = 33;
  localparam int unsigned ProdW    = 2 * MulW;
  localparam int unsigned RotW     = 34;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegDistPerDegree = 3'd0;
  localparam logic [CfgIdxW-1:0] RegTurnPerDegree = 3'd1;
  localparam logic [CfgIdxW-1:0] RegInitX         = 3'd2;
  localparam logic [CfgIdxW-1:0] RegInitY         = 3'd3;
  localparam logic [CfgIdxW-1:0] RegInitHeading   = 3'd4;

  // Register reset values.
  localparam logic [ScaleW-1:0] DistPerDegreeRst = 24'd29739;
  localparam logic [ScaleW-1:0] TurnPerDegreeRst = 24'd2720985;

  // CORDIC start vector, the inverse gain in Q30.
  localparam logic signed [RotW-1:0] CordicGainQ30 = 34'sd652032874;

  // Arctangent of 2^-i as a binary angle, 2^32 per full turn.
  function automatic logic [AngleW-1:0] atan_bam(input logic [AtanIdxW-1:0] idx);
    logic [AngleW-1:0] val;
    unique case (idx)
      5'd0:  val = 32'h20000000;
      5'd1:  val = 32'h12E4051E;
      5'd2:  val = 32'h09FB385B;
      5'd3:  val = 32'h051111D4;
      5'd4:  val = 32'h028B0D43;
      5'd5:  val = 32'h0145D7E1;
      5'd6:  val = 32'h00A2F61E;
      5'd7:  val = 32'h00517C55;
      5'd8:  val = 32'h0028BE53;
      5'd9:  val = 32'h00145F2F;
      5'd10: val = 32'h000A2F98;
      5'd11: val = 32'h000517CC;
      5'd12: val = 32'h00028BE6;
      5'd13: val = 32'h000145F3;
      5'd14: val = 32'h0000A2FA;
      5'd15: val = 32'h0000517D;
      5'd16: val = 32'h000028BE;
      5'd17: val = 32'h0000145F;
      5'd18: val = 32'h00000A30;
      5'd19: val = 32'h00000518;
      5'd20: val = 32'h0000028C;
      5'd21: val = 32'h00000146;
      5'd22: val = 32'h000000A3;
      5'd23: val = 32'h00000051;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

>>> sv/odo_mul.sv
// Shared signed multiplier with a registered product.
module odo_mul (
  input  logic                               clk_i,
  input  logic signed [odo_pkg::MulW-1:0]    a_i,
  input  logic signed [odo_pkg::MulW-1:0]    b_i,
  output logic signed [odo_pkg::ProdW-1:0]   prod_o
);
  import odo_pkg::*;

  logic signed [ProdW-1:0] prod_q;

  // One product per cycle; the sequencer picks the operands.
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

>>> sv/odo_cordic.sv
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle.
module odo_cordic #(
  parameter int unsigned CORDIC_ITERS = odo_pkg::CordicItersDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [odo_pkg::AngleW-1:0]       angle_i,
  output logic                             done_o,
  output logic signed [odo_pkg::MulW-1:0]  cos_o,
  output logic signed [odo_pkg::MulW-1:0]  sin_o
);
  import odo_pkg::*;

  localparam int unsigned IterW = (CORDIC_ITERS > 1) ? $clog2(CORDIC_ITERS) : 1;
  localparam logic [IterW-1:0] IterLast = IterW'(CORDIC_ITERS - 1);

  logic                   busy_q;
  logic [IterW-1:0]       iter_q;
  logic                   flip_q;
  logic signed [RotW-1:0] x_q, y_q, z_q;
  logic signed [RotW-1:0] x_sh, y_sh, atan_ext;
  logic [AngleW-1:0]      quad_sum;
  logic [AngleW-1:0]      ang_fold;
  logic                   flip;
  logic signed [RotW-1:0] cos_full, sin_full;

  // Fold angles in the left half plane by half a turn.
  assign quad_sum = angle_i + 32'h40000000;
  assign flip     = quad_sum[AngleW-1];
  assign ang_fold = flip ? (angle_i ^ 32'h80000000) : angle_i;

  // Shifted operands and table entry for the current iteration.
  assign x_sh     = x_q >>> iter_q;
  assign y_sh     = y_q >>> iter_q;
  assign atan_ext = $signed({2'b00, atan_bam(AtanIdxW'(iter_q))});

  // Rotation registers, one micro-rotation per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      iter_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      iter_q <= '0;
    end else if (busy_q) begin
      iter_q <= iter_q + 1'b1;
      if (iter_q == IterLast) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      flip_q <= flip;
      x_q    <= CordicGainQ30;
      y_q    <= '0;
      z_q    <= RotW'($signed(ang_fold));
    end else if (busy_q) begin
      if (!z_q[RotW-1]) begin
        x_q <= x_q - y_sh;
        y_q <= y_q + x_sh;
        z_q <= z_q - atan_ext;
      end else begin
        x_q <= x_q + y_sh;
        y_q <= y_q - x_sh;
        z_q <= z_q + atan_ext;
      end
    end
  end

  // Undo the fold and hand the results to the multiplier width.
  assign cos_full = flip_q ? -x_q : x_q;
  assign sin_full = flip_q ? -y_q : y_q;
  assign cos_o    = cos_full[MulW-1:0];
  assign sin_o    = sin_full[MulW-1:0];
  assign done_o   = busy_q && (iter_q == IterLast);

endmodule

>>> sv/differential_drive_odometry_core.sv
// Top level of the differential-drive odometry core: sequencer, pose registers and ports.
//
// Usage: each slave-side transaction carries the right and left wheel encoder
// changes of one period. The core turns them into a forward step and a heading
// change, rotates the step by the mid-period heading and adds it to the pose.
// One master-side transaction per input returns x, y and the heading.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i while the
// core is idle; writing init_x, init_y or init_heading also loads the pose.
// Datapath: one shared multiplier does the step, turn, x and y products, and one
// CORDIC unit runs CORDIC_ITERS iterations, one per cycle. An accepted input
// passes the turn product, the CORDIC rotation, the x product, the y product with
// the x update, the y update and the result load; the slave side is ready again
// in the cycle its result is loaded, so the core takes no new item before then.
// The output register holds a result while the receiver stalls, and the core
// takes the next item meanwhile; it only waits before loading a further result.
// Reset clears the pose to zero and loads the default scale registers.
module differential_drive_odometry_core #(
  parameter int unsigned CORDIC_ITERS = odo_pkg::CordicItersDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [odo_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [odo_pkg::CfgDataW-1:0]      cfg_data_i,
  // Encoder input stream.
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [31:0]                       s_axis_tdata_i,  // right_delta, left_delta
  // Pose output stream.
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [95:0]                       m_axis_tdata_o   // pos_x, pos_y, heading
);
  import odo_pkg::*;

  // Sequencer states.
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StMTurn = 3'd1;
  localparam logic [2:0] StAngle = 3'd2;
  localparam logic [2:0] StRot   = 3'd3;
  localparam logic [2:0] StMulX  = 3'd4;
  localparam logic [2:0] StMulY  = 3'd5;
  localparam logic [2:0] StAccY  = 3'd6;
  localparam logic [2:0] StDone  = 3'd7;

  logic [2:0]               state_q, state_d;
  logic [ScaleW-1:0]        dist_q, turn_scale_q;
  logic signed [PosW-1:0]   acc_x_q, acc_y_q;
  logic [AngleW-1:0]        acc_h_q;
  logic signed [DeltaW:0]   diff_q;
  logic signed [PosW-1:0]   step_q;
  logic                     out_valid_q;
  logic [95:0]              out_data_q;

  logic                     in_fire, out_free;
  logic signed [DeltaW-1:0] right_delta, left_delta;
  logic signed [DeltaW:0]   delta_sum, delta_diff;
  logic signed [MulW-1:0]   mul_a, mul_b;
  logic signed [ProdW-1:0]  prod;
  logic signed [ProdW-1:0]  step_round;
  logic [AngleW-1:0]        mid_angle;
  logic                     cordic_start, cordic_done;
  logic signed [MulW-1:0]   cos_v, sin_v;
  logic signed [PosW-1:0]   sat_acc;
  logic signed [PosW+4:0]   sat_sum;
  logic signed [ProdW-1:0]  prod_round;
  logic signed [PosW-1:0]   sat_res;

  // Input unpacking and handshakes.
  assign right_delta     = s_axis_tdata_i[15:0];
  assign left_delta      = s_axis_tdata_i[31:16];
  assign delta_sum       = (DeltaW+1)'(right_delta) + (DeltaW+1)'(left_delta);
  assign delta_diff      = (DeltaW+1)'(right_delta) - (DeltaW+1)'(left_delta);
  assign s_axis_tready_o = (state_q == StIdle);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // Multiplier operand selection.
  always_comb begin
    mul_a = MulW'(delta_sum);
    mul_b = $signed({{(MulW-ScaleW){1'b0}}, dist_q});
    unique case (state_q)
      StMTurn: begin
        mul_a = MulW'(diff_q);
        mul_b = $signed({{(MulW-ScaleW){1'b0}}, turn_scale_q});
      end
      StMulX: begin
        mul_a = MulW'(step_q);
        mul_b = cos_v;
      end
      StMulY: begin
        mul_a = MulW'(step_q);
        mul_b = sin_v;
      end
      default: begin
      end
    endcase
  end

  odo_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Mid-period heading: the pose heading plus half the turn.
  assign mid_angle    = acc_h_q + prod[32:1];
  assign cordic_start = (state_q == StAngle);

  odo_cordic #(
    .CORDIC_ITERS (CORDIC_ITERS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .angle_i (mid_angle),
    .done_o  (cordic_done),
    .cos_o   (cos_v),
    .sin_o   (sin_v)
  );

  // Rounded step and saturating position update.
  assign step_round = prod + ProdW'(256);
  assign prod_round = prod + (ProdW'(1) <<< 29);
  assign sat_acc    = (state_q == StAccY) ? acc_y_q : acc_x_q;
  assign sat_sum    = (PosW+5)'(sat_acc) + (PosW+5)'($signed(prod_round[ProdW-1:30]));

  always_comb begin
    if (sat_sum > (PosW+5)'(64'sh7FFFFFFF)) begin
      sat_res = 32'sh7FFFFFFF;
    end else if (sat_sum < -(PosW+5)'(64'sh80000000)) begin
      sat_res = -32'sh80000000;
    end else begin
      sat_res = sat_sum[PosW-1:0];
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_fire) state_d = StMTurn;
      StMTurn: state_d = StAngle;
      StAngle: state_d = StRot;
      StRot:   if (cordic_done) state_d = StMulX;
      StMulX:  state_d = StMulY;
      StMulY:  state_d = StAccY;
      StAccY:  state_d = StDone;
      StDone:  if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Control, configuration and pose registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      dist_q       <= DistPerDegreeRst;
      turn_scale_q <= TurnPerDegreeRst;
      acc_x_q      <= '0;
      acc_y_q      <= '0;
      acc_h_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegDistPerDegree: dist_q       <= cfg_data_i[ScaleW-1:0];
          RegTurnPerDegree: turn_scale_q <= cfg_data_i[ScaleW-1:0];
          RegInitX:         acc_x_q      <= cfg_data_i;
          RegInitY:         acc_y_q      <= cfg_data_i;
          RegInitHeading:   acc_h_q      <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (state_q == StAngle) begin
        acc_h_q <= acc_h_q + prod[31:0];
      end
      if (state_q == StMulY) begin
        acc_x_q <= sat_res;
      end
      if (state_q == StAccY) begin
        acc_y_q <= sat_res;
      end
      if (state_q == StDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath holding registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      diff_q <= delta_diff;
    end
    if (state_q == StMTurn) begin
      step_q <= step_round[40:9];
    end
    if (state_q == StDone && out_free) begin
      out_data_q <= {acc_h_q, acc_y_q, acc_x_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
